### sv/rcl_pkg.sv
// Shared types and constants for the rotated, clipped line rasterizer.
// No dependencies; used by rcl_map, the top level and the testbench.
package rcl_pkg;

    // Coordinate widths: logical coordinates are signed, screen sizes fit in DIM_W bits
    localparam int COORD_W = 12;
    localparam int DIM_W   = 11;
    localparam int ERR_W   = 14;
    localparam int COLOR_W = 16;
    localparam int FX_W    = 8;
    localparam int FY_W    = 9;
    localparam int ADDR_W  = 17;

    // Command codes
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_STEP  = 1'b1;

    // Display rotation codes
    typedef enum logic [1:0] {
        ROT_NONE  = 2'd0,
        ROT_CW90  = 2'd1,
        ROT_180   = 2'd2,
        ROT_CW270 = 2'd3
    } rot_t;

    // One logical pixel on its way to the mapper
    typedef struct packed {
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        rot_t                      rot;
    } pix_t;

    // Framebuffer write produced by the mapper
    typedef struct packed {
        logic [FX_W-1:0]   frame_x;
        logic [FY_W-1:0]   frame_y;
        logic [ADDR_W-1:0] address;
        logic              enable;
    } map_t;

endpackage

### sv/rcl_map.sv
// Clip a logical pixel against the rotated screen and map it to framebuffer
// coordinates and a linear address. Depends on rcl_pkg.
module rcl_map
    import rcl_pkg::*;
#(
    parameter int FB_WIDTH  = 222,
    parameter int FB_HEIGHT = 480
)
(
    input  pix_t pix,
    output map_t result
);

    localparam logic [DIM_W-1:0] FBW = DIM_W'(FB_WIDTH);
    localparam logic [DIM_W-1:0] FBH = DIM_W'(FB_HEIGHT);

    logic [DIM_W-1:0]  log_w;
    logic [DIM_W-1:0]  log_h;
    logic              on_screen;
    logic [DIM_W-1:0]  ux;
    logic [DIM_W-1:0]  uy;
    logic [DIM_W-1:0]  fx;
    logic [DIM_W-1:0]  fy;
    logic [ADDR_W-1:0] addr;

    // Logical screen swaps its sides on quarter turns
    assign log_w = pix.rot[0] ? FBH : FBW;
    assign log_h = pix.rot[0] ? FBW : FBH;

    assign ux = pix.x[DIM_W-1:0];
    assign uy = pix.y[DIM_W-1:0];

    // Clip against the logical screen
    assign on_screen = !pix.x[COORD_W-1] && !pix.y[COORD_W-1]
                    && (ux < log_w) && (uy < log_h);

    // Rotate to framebuffer coordinates
    always_comb
    begin
        case (pix.rot)
            ROT_CW90:
            begin
                fx = uy;
                fy = FBH - DIM_W'(1) - ux;
            end
            ROT_180:
            begin
                fx = FBW - DIM_W'(1) - ux;
                fy = FBH - DIM_W'(1) - uy;
            end
            ROT_CW270:
            begin
                fx = FBW - DIM_W'(1) - uy;
                fy = ux;
            end
            default:
            begin
                fx = ux;
                fy = uy;
            end
        endcase
    end

    // Row times width plus column, kept modulo the address width
    assign addr = ADDR_W'({{(ADDR_W-DIM_W){1'b0}}, fy} * {{(ADDR_W-DIM_W){1'b0}}, FBW})
                + ADDR_W'(fx);

    // Clipped pixels carry zero coordinates and no write
    assign result.frame_x = on_screen ? fx[FX_W-1:0] : '0;
    assign result.frame_y = on_screen ? fy[FY_W-1:0] : '0;
    assign result.address = on_screen ? addr : '0;
    assign result.enable  = on_screen;

endmodule

### sv/rotated_clipped_line_rasterizer.sv
// Bresenham line engine with screen clipping and display rotation.
// A step word's pixel passes the pixel stage and the output stage registers; start words give none.
// One word per cycle while out_ready back-pressure leaves room; the stepping update is combinational.
// Reset (rst_n low, asynchronous): engine idle, rotation 0, pipeline empty.
// Depends on rcl_pkg and rcl_map.
module rotated_clipped_line_rasterizer
    import rcl_pkg::*;
#(
    parameter int FB_WIDTH  = 222,
    parameter int FB_HEIGHT = 480
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    // Configuration write channel
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [1:0]                 cfg_data,
    // Command channel
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic                       command,
    input  logic signed [COORD_W-1:0]  start_x,
    input  logic signed [COORD_W-1:0]  start_y,
    input  logic signed [COORD_W-1:0]  end_x,
    input  logic signed [COORD_W-1:0]  end_y,
    input  logic [COLOR_W-1:0]         pixel_color,
    // Pixel write channel
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic [FX_W-1:0]            frame_x,
    output logic [FY_W-1:0]            frame_y,
    output logic [ADDR_W-1:0]          pixel_address,
    output logic [COLOR_W-1:0]         write_color,
    output logic                       write_enable,
    output logic                       last_pixel
);

    // Configuration
    rot_t rot_reg;

    // Line state
    logic                      active_reg;
    logic signed [COORD_W-1:0] cur_x_reg, cur_y_reg;
    logic signed [COORD_W-1:0] dest_x_reg, dest_y_reg;
    logic [COORD_W-1:0]        delta_x_reg, delta_y_reg;
    logic                      step_x_neg_reg, step_y_neg_reg;
    logic signed [ERR_W-1:0]   err_reg;
    logic [COLOR_W-1:0]        color_reg;

    // Pixel stage
    logic                      pix_valid_reg;
    pix_t                      pix_reg;
    logic [COLOR_W-1:0]        pix_color_reg;
    logic                      pix_last_reg;

    // Output stage
    logic                      out_valid_reg;
    map_t                      out_map_reg;
    logic [COLOR_W-1:0]        out_color_reg;
    logic                      out_last_reg;

    logic                      adv_out;
    logic                      adv_pix;
    logic                      in_acc;
    logic                      do_start;
    logic                      do_step;
    logic                      at_dest;
    map_t                      mapped;

    // Start setup
    logic signed [COORD_W:0]   diff_x, diff_y;
    logic [COORD_W-1:0]        abs_x, abs_y;
    logic signed [ERR_W-1:0]   err_start;

    // Step update
    logic signed [ERR_W:0]     e2;
    logic                      move_x, move_y;
    logic signed [ERR_W:0]     err_step;

    // Handshake flow
    assign adv_out   = !out_valid_reg || out_ready;
    assign adv_pix   = !pix_valid_reg || adv_out;
    assign in_ready  = adv_pix;
    assign cfg_ready = 1'b1;
    assign in_acc    = in_valid && in_ready;
    assign do_start  = in_acc && (command == CMD_START);
    assign do_step   = in_acc && (command == CMD_STEP) && active_reg;

    assign at_dest = (cur_x_reg == dest_x_reg) && (cur_y_reg == dest_y_reg);

    // Absolute deltas and initial error
    assign diff_x    = (COORD_W+1)'(end_x) - (COORD_W+1)'(start_x);
    assign diff_y    = (COORD_W+1)'(end_y) - (COORD_W+1)'(start_y);
    assign abs_x     = diff_x[COORD_W] ? COORD_W'(-diff_x) : diff_x[COORD_W-1:0];
    assign abs_y     = diff_y[COORD_W] ? COORD_W'(-diff_y) : diff_y[COORD_W-1:0];
    assign err_start = $signed(ERR_W'({1'b0, abs_x})) - $signed(ERR_W'({1'b0, abs_y}));

    // Integer error rule
    assign e2       = {err_reg, 1'b0};
    assign move_x   = e2 > -$signed((ERR_W+1)'({1'b0, delta_y_reg}));
    assign move_y   = e2 < $signed((ERR_W+1)'({1'b0, delta_x_reg}));
    assign err_step = (ERR_W+1)'(err_reg)
                    - (move_x ? $signed((ERR_W+1)'({1'b0, delta_y_reg})) : '0)
                    + (move_y ? $signed((ERR_W+1)'({1'b0, delta_x_reg})) : '0);

    // Hold rotation
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rot_reg <= ROT_NONE;
        else if (cfg_valid && cfg_ready)
            rot_reg <= rot_t'(cfg_data);
    end

    // Advance line state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg     <= 1'b0;
            cur_x_reg      <= '0;
            cur_y_reg      <= '0;
            dest_x_reg     <= '0;
            dest_y_reg     <= '0;
            delta_x_reg    <= '0;
            delta_y_reg    <= '0;
            step_x_neg_reg <= 1'b0;
            step_y_neg_reg <= 1'b0;
            err_reg        <= '0;
            color_reg      <= '0;
        end
        else if (do_start)
        begin
            active_reg     <= 1'b1;
            cur_x_reg      <= start_x;
            cur_y_reg      <= start_y;
            dest_x_reg     <= end_x;
            dest_y_reg     <= end_y;
            delta_x_reg    <= abs_x;
            delta_y_reg    <= abs_y;
            step_x_neg_reg <= !(start_x < end_x);
            step_y_neg_reg <= !(start_y < end_y);
            err_reg        <= err_start;
            color_reg      <= pixel_color;
        end
        else if (do_step)
        begin
            if (at_dest)
                active_reg <= 1'b0;
            else
            begin
                err_reg <= err_step[ERR_W-1:0];
                if (move_x)
                    cur_x_reg <= step_x_neg_reg ? cur_x_reg - COORD_W'(1)
                                                : cur_x_reg + COORD_W'(1);
                if (move_y)
                    cur_y_reg <= step_y_neg_reg ? cur_y_reg - COORD_W'(1)
                                                : cur_y_reg + COORD_W'(1);
            end
        end
    end

    // Pixel stage: capture the current point
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            pix_valid_reg <= 1'b0;
        else if (adv_pix)
            pix_valid_reg <= do_step;
    end

    always_ff @(posedge clk)
    begin
        if (adv_pix && do_step)
        begin
            pix_reg.x     <= cur_x_reg;
            pix_reg.y     <= cur_y_reg;
            pix_reg.rot   <= rot_reg;
            pix_color_reg <= color_reg;
            pix_last_reg  <= at_dest;
        end
    end

    rcl_map #(
        .FB_WIDTH  (FB_WIDTH),
        .FB_HEIGHT (FB_HEIGHT)
    ) u_map (
        .pix    (pix_reg),
        .result (mapped)
    );

    // Output stage: hold until taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (adv_out)
            out_valid_reg <= pix_valid_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv_out && pix_valid_reg)
        begin
            out_map_reg   <= mapped;
            out_color_reg <= pix_color_reg;
            out_last_reg  <= pix_last_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign frame_x       = out_map_reg.frame_x;
    assign frame_y       = out_map_reg.frame_y;
    assign pixel_address = out_map_reg.address;
    assign write_color   = out_color_reg;
    assign write_enable  = out_map_reg.enable;
    assign last_pixel    = out_last_reg;

    // A step while idle never makes a pixel
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_acc && command == CMD_STEP && !active_reg) |=> !pix_valid_reg)
        else $error("pixel produced by a step while idle");

    // Reaching the end point idles the engine
    assert property (@(posedge clk) disable iff (!rst_n)
        (do_step && at_dest) |=> !active_reg)
        else $error("engine still active after its last pixel");

    // A clipped pixel has zero coordinates and address
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !write_enable) |->
            (frame_x == '0 && frame_y == '0 && pixel_address == '0))
        else $error("clipped pixel with nonzero coordinates");

    // Input stalls only when both stages are full and the sink stalls
    assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (pix_valid_reg && out_valid_reg && !out_ready))
        else $error("input stalled with room in the pipeline");

endmodule

### tb/rcl_pixel_checker.sv
// Pixel write checker for the rotated, clipped line rasterizer.
// Watches the config, command and pixel channels, predicts each pixel write
// and compares it field by field. Depends on rcl_pkg.
module rcl_pixel_checker
    import rcl_pkg::*;
#(
    parameter int FB_WIDTH  = 222,
    parameter int FB_HEIGHT = 480
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [1:0]                cfg_data,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  logic                      command,
    input  logic signed [COORD_W-1:0] start_x,
    input  logic signed [COORD_W-1:0] start_y,
    input  logic signed [COORD_W-1:0] end_x,
    input  logic signed [COORD_W-1:0] end_y,
    input  logic [COLOR_W-1:0]        pixel_color,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  logic [FX_W-1:0]           frame_x,
    input  logic [FY_W-1:0]           frame_y,
    input  logic [ADDR_W-1:0]         pixel_address,
    input  logic [COLOR_W-1:0]        write_color,
    input  logic                      write_enable,
    input  logic                      last_pixel,
    output int                        error_count,
    output int                        pixels_pending
);

    typedef struct packed {
        logic [FX_W-1:0]    fx;
        logic [FY_W-1:0]    fy;
        logic [ADDR_W-1:0]  addr;
        logic [COLOR_W-1:0] color;
        logic               enable;
        logic               last;
    } pixel_write_t;

    // Line engine state as the block should hold it
    rot_t                      rotation;
    logic                      engine_active;
    logic signed [COORD_W-1:0] cur_x;
    logic signed [COORD_W-1:0] cur_y;
    logic signed [COORD_W-1:0] dest_x;
    logic signed [COORD_W-1:0] dest_y;
    logic [COORD_W-1:0]        delta_x;
    logic [COORD_W-1:0]        delta_y;
    logic                      neg_x;
    logic                      neg_y;
    logic signed [ERR_W-1:0]   err_term;
    logic [COLOR_W-1:0]        line_color;

    pixel_write_t pending_writes[$];
    int           mismatches = 0;
    int           queued     = 0;

    assign error_count    = mismatches;
    assign pixels_pending = queued;

    task automatic report_error(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        mismatches++;
    endtask

    // Latch a new line, or emit and advance one pixel of the running line
    task automatic follow_command();
        int           x0;
        int           y0;
        int           x1;
        int           y1;
        int           x;
        int           y;
        int           fx;
        int           fy;
        int           lw;
        int           lh;
        int           e2;
        int           err;
        bit           on_screen;
        pixel_write_t px;
        if (command == CMD_START)
        begin
            x0 = int'(start_x);
            y0 = int'(start_y);
            x1 = int'(end_x);
            y1 = int'(end_y);
            cur_x  = start_x;
            cur_y  = start_y;
            dest_x = end_x;
            dest_y = end_y;
            delta_x  = COORD_W'(x1 > x0 ? x1 - x0 : x0 - x1);
            delta_y  = COORD_W'(y1 > y0 ? y1 - y0 : y0 - y1);
            neg_x    = !(x0 < x1);
            neg_y    = !(y0 < y1);
            err_term = ERR_W'(int'(delta_x) - int'(delta_y));
            line_color    = pixel_color;
            engine_active = 1'b1;
        end
        else if (engine_active)
        begin
            // Clip against the logical screen, then rotate into the framebuffer
            lw = rotation[0] ? FB_HEIGHT : FB_WIDTH;
            lh = rotation[0] ? FB_WIDTH : FB_HEIGHT;
            x  = int'(cur_x);
            y  = int'(cur_y);
            fx = 0;
            fy = 0;
            on_screen = (x >= 0) && (x < lw) && (y >= 0) && (y < lh);
            if (on_screen)
            begin
                case (rotation)
                    ROT_CW90:
                    begin
                        fx = y;
                        fy = FB_HEIGHT - 1 - x;
                    end
                    ROT_180:
                    begin
                        fx = FB_WIDTH - 1 - x;
                        fy = FB_HEIGHT - 1 - y;
                    end
                    ROT_CW270:
                    begin
                        fx = FB_WIDTH - 1 - y;
                        fy = x;
                    end
                    default:
                    begin
                        fx = x;
                        fy = y;
                    end
                endcase
            end
            px.fx     = FX_W'(fx);
            px.fy     = FY_W'(fy);
            px.addr   = on_screen ? ADDR_W'(fy * FB_WIDTH + fx) : '0;
            px.color  = line_color;
            px.enable = on_screen;
            px.last   = (cur_x == dest_x) && (cur_y == dest_y);
            pending_writes.push_back(px);

            // Advance by the integer error rule, or go idle at the end point
            if (px.last)
                engine_active = 1'b0;
            else
            begin
                err = int'(err_term);
                e2  = 2 * err;
                if (e2 > -int'(delta_y))
                begin
                    err   = err - int'(delta_y);
                    cur_x = COORD_W'(x + (neg_x ? -1 : 1));
                end
                if (e2 < int'(delta_x))
                begin
                    err   = err + int'(delta_x);
                    cur_y = COORD_W'(y + (neg_y ? -1 : 1));
                end
                err_term = ERR_W'(err);
            end
        end
    endtask

    // Compare one accepted pixel word with the oldest pending write
    task automatic check_pixel();
        pixel_write_t want;
        if (pending_writes.size() == 0)
        begin
            report_error($sformatf("unexpected pixel word: frame %0d,%0d addr %0d",
                                   frame_x, frame_y, pixel_address));
        end
        else
        begin
            want = pending_writes.pop_front();
            if (frame_x !== want.fx)
                report_error($sformatf("frame_x %0d, want %0d", frame_x, want.fx));
            if (frame_y !== want.fy)
                report_error($sformatf("frame_y %0d, want %0d", frame_y, want.fy));
            if (pixel_address !== want.addr)
                report_error($sformatf("pixel_address %0d, want %0d",
                                       pixel_address, want.addr));
            if (write_color !== want.color)
                report_error($sformatf("write_color %h, want %h", write_color, want.color));
            if (write_enable !== want.enable)
                report_error($sformatf("write_enable %b, want %b",
                                       write_enable, want.enable));
            if (last_pixel !== want.last)
                report_error($sformatf("last_pixel %b, want %b", last_pixel, want.last));
        end
    endtask

    // Track every handshake at the rising edge
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rotation      = ROT_NONE;
            engine_active = 1'b0;
            cur_x         = '0;
            cur_y         = '0;
            dest_x        = '0;
            dest_y        = '0;
            delta_x       = '0;
            delta_y       = '0;
            neg_x         = 1'b0;
            neg_y         = 1'b0;
            err_term      = '0;
            line_color    = '0;
            pending_writes.delete();
            queued        = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
                rotation = rot_t'(cfg_data);
            if (in_valid && in_ready)
                follow_command();
            if (out_valid && out_ready)
                check_pixel();
            queued = pending_writes.size();
        end
    end

endmodule

### tb/tb_top.sv
// Testbench top for the rotated, clipped line rasterizer.
// Drives directed and random line commands under every rotation; relies on
// rcl_pkg, the rasterizer and rcl_pixel_checker.
module tb_top;
    import rcl_pkg::*;

    localparam int FB_WIDTH  = 222;
    localparam int FB_HEIGHT = 480;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                      cfg_valid   = 1'b0;
    logic                      cfg_ready;
    logic [1:0]                cfg_data    = '0;
    logic                      in_valid    = 1'b0;
    logic                      in_ready;
    logic                      command     = CMD_START;
    logic signed [COORD_W-1:0] start_x     = '0;
    logic signed [COORD_W-1:0] start_y     = '0;
    logic signed [COORD_W-1:0] end_x       = '0;
    logic signed [COORD_W-1:0] end_y       = '0;
    logic [COLOR_W-1:0]        pixel_color = '0;
    logic                      out_valid;
    logic                      out_ready   = 1'b0;
    logic [FX_W-1:0]           frame_x;
    logic [FY_W-1:0]           frame_y;
    logic [ADDR_W-1:0]         pixel_address;
    logic [COLOR_W-1:0]        write_color;
    logic                      write_enable;
    logic                      last_pixel;

    int check_errors;
    int pixels_pending;

    // Stimulus state
    rot_t cur_rot        = ROT_NONE;
    int   steps_left     = 0;
    bit   line_drawn_out = 1'b1;
    bit   steady         = 1'b0;
    bit   hold_request   = 1'b0;
    bit   hold_served    = 1'b0;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    rotated_clipped_line_rasterizer #(
        .FB_WIDTH  (FB_WIDTH),
        .FB_HEIGHT (FB_HEIGHT)
    ) u_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .command       (command),
        .start_x       (start_x),
        .start_y       (start_y),
        .end_x         (end_x),
        .end_y         (end_y),
        .pixel_color   (pixel_color),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .frame_x       (frame_x),
        .frame_y       (frame_y),
        .pixel_address (pixel_address),
        .write_color   (write_color),
        .write_enable  (write_enable),
        .last_pixel    (last_pixel)
    );

    rcl_pixel_checker #(
        .FB_WIDTH  (FB_WIDTH),
        .FB_HEIGHT (FB_HEIGHT)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .command        (command),
        .start_x        (start_x),
        .start_y        (start_y),
        .end_x          (end_x),
        .end_y          (end_y),
        .pixel_color    (pixel_color),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .frame_x        (frame_x),
        .frame_y        (frame_y),
        .pixel_address  (pixel_address),
        .write_color    (write_color),
        .write_enable   (write_enable),
        .last_pixel     (last_pixel),
        .error_count    (check_errors),
        .pixels_pending (pixels_pending)
    );

    // Offer one command word, with random gaps before it, and hold it until taken
    task automatic send_word(input logic cmd, input int sx, input int sy, input int ex,
                             input int ey, input logic [COLOR_W-1:0] col);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 38)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        command     <= cmd;
        start_x     <= COORD_W'(sx);
        start_y     <= COORD_W'(sy);
        end_x       <= COORD_W'(ex);
        end_y       <= COORD_W'(ey);
        pixel_color <= col;
        do @(posedge clk); while (!in_ready);
    endtask

    task automatic release_input();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Change rotation once every pixel has drained and the pipeline has settled
    task automatic write_rotation(input rot_t rot);
        while (pixels_pending != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= rot;
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        cur_rot = rot;
    endtask

    // Mostly complete lines around the screen, some cut short by a new start
    task automatic run_phase(input int count);
        int                 done_items;
        int                 kind;
        int                 lw;
        int                 lh;
        int                 x0;
        int                 y0;
        int                 x1;
        int                 y1;
        int                 pick;
        int                 dxa;
        int                 dya;
        int                 pixels;
        logic [COLOR_W-1:0] color;
        done_items = 0;
        lw = cur_rot[0] ? FB_HEIGHT : FB_WIDTH;
        lh = cur_rot[0] ? FB_WIDTH : FB_HEIGHT;
        while (done_items < count)
        begin
            if (steps_left > 0)
            begin
                send_word(CMD_STEP, $urandom, $urandom, $urandom, $urandom,
                          COLOR_W'($urandom));
                steps_left--;
                done_items++;
            end
            else if (line_drawn_out && $urandom_range(0, 99) < 4)
            begin
                // stray step on an idle engine
                send_word(CMD_STEP, $urandom, $urandom, $urandom, $urandom,
                          COLOR_W'($urandom));
            end
            else
            begin
                kind = $urandom_range(0, 99);
                x0 = $urandom_range(0, lw + 19) - 10;
                y0 = $urandom_range(0, lh + 19) - 10;
                x1 = x0 + $urandom_range(0, 48) - 24;
                y1 = y0 + $urandom_range(0, 48) - 24;
                if (kind >= 70 && kind < 85)
                begin
                    // run along one screen edge, just inside or just outside
                    pick = $urandom_range(0, 3);
                    if ($urandom_range(0, 1) == 0)
                    begin
                        x0 = (pick < 2) ? pick - 1 : lw + pick - 3;
                        x1 = x0;
                    end
                    else
                    begin
                        y0 = (pick < 2) ? pick - 1 : lh + pick - 3;
                        y1 = y0;
                    end
                end
                else if (kind >= 85 && kind < 95)
                begin
                    x0 = $urandom_range(0, 4095) - 2048;
                    y0 = $urandom_range(0, 4095) - 2048;
                    x1 = $urandom_range(0, 4095) - 2048;
                    y1 = $urandom_range(0, 4095) - 2048;
                end
                else if (kind >= 95)
                begin
                    x0 = $urandom_range(0, lw - 1);
                    y0 = $urandom_range(0, lh - 1);
                    x1 = x0 + $urandom_range(0, 512) - 256;
                    y1 = y0 + $urandom_range(0, 512) - 256;
                end
                dxa    = (x1 > x0) ? x1 - x0 : x0 - x1;
                dya    = (y1 > y0) ? y1 - y0 : y0 - y1;
                pixels = ((dxa > dya) ? dxa : dya) + 1;
                steps_left     = pixels;
                line_drawn_out = 1'b1;
                if (kind >= 85 && kind < 95)
                begin
                    // drop the long line after a few pixels
                    steps_left = $urandom_range(0, 6);
                    if (steps_left < pixels)
                        line_drawn_out = 1'b0;
                    else
                        steps_left = pixels;
                end
                pick = $urandom_range(0, 9);
                color = (pick == 0) ? 16'h0000 : (pick == 1) ? 16'hFFFF : COLOR_W'($urandom);
                send_word(CMD_START, x0, y0, x1, y1, color);
                done_items++;
            end
        end
    endtask

    // Receiver: random stalls, one long hold-off, and a stretch with none
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_request && !hold_served)
            begin
                out_ready <= 1'b0;
                repeat (300) @(negedge clk);
                hold_served = 1'b1;
            end
            else
                out_ready <= steady || ($urandom_range(0, 99) >= 38);
        end
    end

    // Main stimulus and verdict
    initial
    begin
        rot_t phase_rot [8];
        int   drain_cycles;
        phase_rot = '{ROT_CW270, ROT_CW90, ROT_180, ROT_NONE,
                      ROT_180, ROT_CW90, ROT_CW270, ROT_NONE};
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_rotation(ROT_NONE);

        // Step with no line running
        send_word(CMD_STEP, 0, 0, 0, 0, 16'h0000);
        // Single-point line at the far screen corner
        send_word(CMD_START, 221, 479, 221, 479, 16'hFFFF);
        send_word(CMD_STEP, 0, 0, 0, 0, 16'h0000);
        // Diagonal through the origin, first pixel clipped
        send_word(CMD_START, -1, -1, 1, 1, 16'h0000);
        repeat (3) send_word(CMD_STEP, -1, -1, -1, -1, 16'hFFFF);
        // Full-range line, replaced by a new start while still running
        send_word(CMD_START, 2047, -2048, -2048, 2047, 16'h5A5A);
        repeat (2) send_word(CMD_STEP, 0, 0, 0, 0, 16'h0000);
        send_word(CMD_START, 220, 478, 222, 480, 16'hA5A5);
        repeat (3) send_word(CMD_STEP, 0, 0, 0, 0, 16'h0000);
        send_word(CMD_STEP, 0, 0, 0, 0, 16'h0000);
        // Rotation change in the middle of a line
        send_word(CMD_START, 0, 0, 3, 0, 16'h1234);
        repeat (2) send_word(CMD_STEP, 0, 0, 0, 0, 16'h0000);
        release_input();
        write_rotation(ROT_CW270);
        repeat (2) send_word(CMD_STEP, 0, 0, 0, 0, 16'h0000);
        release_input();

        // Random phases, one rotation each; lines may run across a change
        for (int p = 0; p < 8; p++)
        begin
            write_rotation(phase_rot[p]);
            hold_request = (p == 1);
            steady       = (p == 4);
            run_phase(240);
            release_input();
        end
        steady = 1'b0;

        // Drain the remaining pixel words, then let the pipeline settle
        drain_cycles = 0;
        while (pixels_pending != 0 && drain_cycles < 20000)
        begin
            @(negedge clk);
            drain_cycles++;
        end
        repeat (8) @(negedge clk);

        if (check_errors == 0 && pixels_pending == 0)
        begin
            $display("simulation ok");
        end
        else
        begin
            $display("simulation failed");
        end
        $finish;
    end

    // Hard stop if the run hangs
    initial
    begin
        #5000000;
        $display("simulation failed");
        $finish;
    end

endmodule
